[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RBSI_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RBSI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/rbsi_pkg.sv]
// ---------------------------------------------------------------------------
// rbsi_pkg
// Types, constants and helpers of the ray/box slab intersection unit.
// ---------------------------------------------------------------------------
package rbsi_pkg;

   localparam int AXES  = 3;
   localparam int LANES = 2 * AXES;   // near and far division per axis
   localparam int Q_W   = 32;         // Q16.16 word
   localparam int NUM_W = 48;         // |plane - origin| * 2^16
   localparam int DEN_W = 32;         // |direction|
   localparam int T_W   = 50;         // signed distance with infinity codes

   localparam logic signed [T_W-1:0] T_POS_INF = {2'b00, {(T_W-2){1'b1}}};
   localparam logic signed [T_W-1:0] T_NEG_INF = -T_POS_INF;

   // Configuration register indexes.
   localparam logic [2:0] REG_MIN_X = 3'd0;
   localparam logic [2:0] REG_MIN_Y = 3'd1;
   localparam logic [2:0] REG_MIN_Z = 3'd2;
   localparam logic [2:0] REG_MAX_X = 3'd3;
   localparam logic [2:0] REG_MAX_Y = 3'd4;
   localparam logic [2:0] REG_MAX_Z = 3'd5;

   typedef struct packed {
      logic [LANES-1:0] neg;      // quotient sign per lane
      logic [AXES-1:0]  zero;     // direction component is zero
      logic [AXES-1:0]  in_slab;  // origin within slab, inclusive
   } side_type;

   typedef struct packed {
      logic [LANES-1:0][NUM_W-1:0] num;
      logic [LANES-1:0][DEN_W-1:0] den;
      side_type                    side;
   } div_in_type;

   typedef struct packed {
      logic [LANES-1:0][NUM_W-1:0] quo;
      side_type                    side;
   } div_out_type;

   typedef struct packed {
      logic            hit;
      logic [Q_W-1:0]  t_enter;
      logic [Q_W-1:0]  t_exit;
   } result_type;

   function automatic logic [Q_W-1:0] sat_q(input logic signed [T_W-1:0] v);
      logic signed [T_W-1:0] hi;
      logic signed [T_W-1:0] lo;
      hi = T_W'(64'sd2147483647);
      lo = -T_W'(64'sd2147483648);
      if (v > hi) begin
         return 32'h7FFF_FFFF;
      end else if (v < lo) begin
         return 32'h8000_0000;
      end
      return v[Q_W-1:0];
   endfunction

endpackage

[sv/rbsi_prep.sv]
// ---------------------------------------------------------------------------
// rbsi_prep
// Forms numerator and divisor magnitudes and slab flags for all six lanes.
// ---------------------------------------------------------------------------
module rbsi_prep import rbsi_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [AXES-1:0][Q_W-1:0]  origin,
   input  logic [AXES-1:0][Q_W-1:0]  direction,
   input  logic [AXES-1:0][Q_W-1:0]  box_min,
   input  logic [AXES-1:0][Q_W-1:0]  box_max,
   output logic                      out_valid,
   output div_in_type                out_data
);

   logic       valid_ff;
   div_in_type data_ff;
   div_in_type data_in;

   always_comb begin
      logic signed [Q_W:0] d_lo;
      logic signed [Q_W:0] d_hi;
      logic signed [Q_W:0] d_near;
      logic signed [Q_W:0] d_far;
      logic signed [Q_W:0] dir_ext;
      logic [Q_W:0]        dir_mag;
      logic [Q_W:0]        n_mag;
      logic [Q_W:0]        f_mag;
      logic                dneg;
      data_in = '0;
      for (int a = 0; a < AXES; a++) begin
         d_lo    = $signed({box_min[a][Q_W-1], box_min[a]})
                   - $signed({origin[a][Q_W-1], origin[a]});
         d_hi    = $signed({box_max[a][Q_W-1], box_max[a]})
                   - $signed({origin[a][Q_W-1], origin[a]});
         dneg    = direction[a][Q_W-1];
         d_near  = dneg ? d_hi : d_lo;
         d_far   = dneg ? d_lo : d_hi;
         dir_ext = $signed({dneg, direction[a]});
         dir_mag = dneg ? (Q_W+1)'(-dir_ext) : (Q_W+1)'(dir_ext);
         n_mag   = d_near[Q_W] ? (Q_W+1)'(-d_near) : (Q_W+1)'(d_near);
         f_mag   = d_far[Q_W]  ? (Q_W+1)'(-d_far)  : (Q_W+1)'(d_far);
         data_in.num[2*a]       = {n_mag[Q_W-1:0], 16'h0000};
         data_in.num[2*a+1]     = {f_mag[Q_W-1:0], 16'h0000};
         data_in.den[2*a]       = dir_mag[DEN_W-1:0];
         data_in.den[2*a+1]     = dir_mag[DEN_W-1:0];
         data_in.side.neg[2*a]   = d_near[Q_W] ^ dneg;
         data_in.side.neg[2*a+1] = d_far[Q_W] ^ dneg;
         data_in.side.zero[a]    = (direction[a] == '0);
         data_in.side.in_slab[a] = (d_lo <= 0) && (d_hi >= 0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[sv/rbsi_divider.sv]
// ---------------------------------------------------------------------------
// rbsi_divider
// Pipelined restoring divider, one quotient bit per stage, six lanes wide.
// ---------------------------------------------------------------------------
module rbsi_divider import rbsi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  div_in_type  in_data,
   output logic        out_valid,
   output div_out_type out_data
);

   logic [LANES-1:0][DEN_W-1:0] rem_ff  [0:NUM_W-1];
   logic [LANES-1:0][NUM_W-1:0] nq_ff   [0:NUM_W-1];
   logic [LANES-1:0][DEN_W-1:0] den_ff  [0:NUM_W-1];
   side_type                    side_ff [0:NUM_W-1];
   logic                        vld_ff  [0:NUM_W-1];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [LANES-1:0][DEN_W-1:0] rem_prev;
      logic [LANES-1:0][NUM_W-1:0] nq_prev;
      logic [LANES-1:0][DEN_W-1:0] den_prev;
      side_type                    side_prev;
      logic                        vld_prev;
      logic [LANES-1:0][DEN_W-1:0] rem_in;
      logic [LANES-1:0][NUM_W-1:0] nq_in;

      if (s == 0) begin : g_first
         assign rem_prev  = '0;
         assign nq_prev   = in_data.num;
         assign den_prev  = in_data.den;
         assign side_prev = in_data.side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign nq_prev   = nq_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign vld_prev  = vld_ff[s-1];
      end

      always_comb begin
         logic [DEN_W:0] trial;
         logic           take;
         for (int l = 0; l < LANES; l++) begin
            trial     = {rem_prev[l], nq_prev[l][NUM_W-1]};
            take      = (trial >= {1'b0, den_prev[l]});
            rem_in[l] = take ? DEN_W'(trial - {1'b0, den_prev[l]}) : trial[DEN_W-1:0];
            nq_in[l]  = {nq_prev[l][NUM_W-2:0], take};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_prev;
         end
         if (en) begin
            rem_ff[s]  <= rem_in;
            nq_ff[s]   <= nq_in;
            den_ff[s]  <= den_prev;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid     = vld_ff[NUM_W-1];
   assign out_data.quo  = nq_ff[NUM_W-1];
   assign out_data.side = side_ff[NUM_W-1];

endmodule

[sv/rbsi_merge.sv]
// ---------------------------------------------------------------------------
// rbsi_merge
// Signs the quotients, then narrows the interval over x and y, then z.
// ---------------------------------------------------------------------------
module rbsi_merge import rbsi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  div_out_type in_data,
   output logic        out_valid,
   output result_type  out_data
);

   logic signed [T_W-1:0] tn_ff [AXES];
   logic signed [T_W-1:0] tn_in [AXES];
   logic signed [T_W-1:0] tf_ff [AXES];
   logic signed [T_W-1:0] tf_in [AXES];
   logic [AXES-1:0]       ok_ff, ok_in;
   logic                  v1_ff;

   logic signed [T_W-1:0] xn_ff, xn_in, xf_ff, xf_in, zn_ff, zf_ff;
   logic                  h2_ff, h2_in, okz_ff, v2_ff;

   always_comb begin
      logic signed [T_W-1:0] qn;
      logic signed [T_W-1:0] qf;
      for (int a = 0; a < AXES; a++) begin
         qn = $signed({2'b00, in_data.quo[2*a]});
         qf = $signed({2'b00, in_data.quo[2*a+1]});
         if (in_data.side.neg[2*a])   qn = -qn;
         if (in_data.side.neg[2*a+1]) qf = -qf;
         tn_in[a] = in_data.side.zero[a] ? T_NEG_INF : qn;
         tf_in[a] = in_data.side.zero[a] ? T_POS_INF : qf;
         ok_in[a] = !in_data.side.zero[a] || in_data.side.in_slab[a];
      end
   end

   always_comb begin
      h2_in = ok_ff[0] && ok_ff[1] && !(tn_ff[0] > tf_ff[1] || tn_ff[1] > tf_ff[0]);
      xn_in = (tn_ff[1] > tn_ff[0]) ? tn_ff[1] : tn_ff[0];
      xf_in = (tf_ff[1] < tf_ff[0]) ? tf_ff[1] : tf_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (en) begin
         tn_ff  <= tn_in;
         tf_ff  <= tf_in;
         ok_ff  <= ok_in;
         h2_ff  <= h2_in;
         xn_ff  <= xn_in;
         xf_ff  <= xf_in;
         zn_ff  <= tn_ff[2];
         zf_ff  <= tf_ff[2];
         okz_ff <= ok_ff[2];
      end
   end

   always_comb begin
      logic                  hit;
      logic signed [T_W-1:0] rn;
      logic signed [T_W-1:0] rf;
      hit = h2_ff && okz_ff && !(xn_ff > zf_ff || zn_ff > xf_ff);
      rn  = (zn_ff > xn_ff) ? zn_ff : xn_ff;
      rf  = (zf_ff < xf_ff) ? zf_ff : xf_ff;
      out_data.hit     = hit;
      out_data.t_enter = hit ? sat_q(rn) : '0;
      out_data.t_exit  = hit ? sat_q(rf) : '0;
   end

   assign out_valid = v2_ff;

endmodule

[sv/ray_box_slab_intersect_unit.sv]
// ---------------------------------------------------------------------------
// ray_box_slab_intersect_unit
// Ray against axis-aligned box by the slab method, signed Q16.16.
// ---------------------------------------------------------------------------
// Each req transaction carries one ray: origin x, y, z and direction x, y, z.
// Each ray produces exactly one rsp transaction with a hit flag and the entry
// and exit distances, saturated to Q16.16, or zeros on a miss.
// The box corners are written through the csr port (index 0..2 min x,y,z,
// index 3..5 max x,y,z) only while no ray is in flight; the user must ensure
// this, the block does not enforce it. The prep register loads the numerators
// and divisors, the 48 divider stages, which set the latency, run six
// restoring dividers one quotient bit per stage, the merge registers combine
// the slabs and the output register loads the result. Throughput is one ray
// per clock cycle unless the pipeline is frozen; every stage carries its own
// valid. When the receiver stalls, the result moves into a skid register and
// the pipeline freezes only while that register is full, so req_tready drops
// in the cycle after a stall at the earliest and nothing is lost. Synchronous
// reset clears all valid bits and loads the unit box [0,1]^3.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_box_slab_intersect_unit import rbsi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit [0], t_enter [32:1], t_exit [64:33], zero pad [71:65]
   output logic [71:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   // Box registers.
   logic [AXES-1:0][Q_W-1:0] box_min_ff, box_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_ff <= '0;
         box_max_ff <= {AXES{32'h0001_0000}};
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_MIN_X: box_min_ff[0] <= csr_wdata;
            REG_MIN_Y: box_min_ff[1] <= csr_wdata;
            REG_MIN_Z: box_min_ff[2] <= csr_wdata;
            REG_MAX_X: box_max_ff[0] <= csr_wdata;
            REG_MAX_Y: box_max_ff[1] <= csr_wdata;
            REG_MAX_Z: box_max_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline advances unless the skid register holds a result.
   logic        skid_valid_ff, skid_valid_in;
   result_type  skid_ff, skid_in;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;
   logic        pipe_en;

   assign pipe_en    = !skid_valid_ff;
   assign req_tready = pipe_en;

   logic [AXES-1:0][Q_W-1:0] origin, direction;
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         origin[a]    = req_tdata[a*Q_W +: Q_W];
         direction[a] = req_tdata[(a+AXES)*Q_W +: Q_W];
      end
   end

   logic        prep_valid, div_valid, merge_valid;
   div_in_type  prep_data;
   div_out_type div_data;
   result_type  merge_data;

   rbsi_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_tvalid),
      .origin    (origin),
      .direction (direction),
      .box_min   (box_min_ff),
      .box_max   (box_max_ff),
      .out_valid (prep_valid),
      .out_data  (prep_data)
   );

   rbsi_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (prep_valid),
      .in_data   (prep_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   rbsi_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (merge_valid),
      .out_data  (merge_data)
   );

   // Output register with skid register behind it.
   always_comb begin
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_in = merge_valid;
         out_in       = merge_data;
      end else if (merge_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = merge_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      skid_ff <= skid_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_ff.t_exit, out_ff.t_enter, out_ff.hit};

   `RBSI_ASSERT_IMPL(a_skid_behind_out, skid_valid_ff, rsp_tvalid,
      "skid register full while output register empty")
   `RBSI_ASSERT_NEXT(a_skid_holds, skid_valid_ff && !rsp_tready, skid_valid_ff,
      "skid register emptied without a transaction")
   `RBSI_ASSERT_IMPL(a_miss_zero, rsp_tvalid && !rsp_tdata[0], rsp_tdata[64:1] == '0,
      "miss result carries nonzero distances")

endmodule

[tb/sv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the ray/box slab intersection unit.
// ---------------------------------------------------------------------------
// Rays are sent in bursts with random gaps. Each ray's expected hit flag and
// entry/exit distances are computed by a local slab predictor at the moment
// the request transaction is accepted, and queued. Response transactions are
// compared field by field against the oldest queued expectation. The box is
// reprogrammed between phases, only once the pipeline has drained.
// ---------------------------------------------------------------------------
module testbench;
   import rbsi_pkg::*;

   localparam longint Q_ONE_L = 65536;
   localparam longint T_UNB = 64'sd1 <<< 62;
   localparam int LIMIT = 2000000;
   localparam int N_RANDOM = 1800;

   typedef struct packed {
      logic [31:0] dz, dy, dx, oz, oy, ox;
   } ray_type;

   typedef struct {
      ray_type ray;
      bit      check_fixed;
      result_type fixed_res;
   } row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [191:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;
   logic         csr_we;
   logic [2:0]   csr_addr;
   logic [31:0]  csr_wdata;

   // Box corners as seen by the predictor: min x,y,z then max x,y,z.
   longint box_lo [3];
   longint box_hi [3];

   // Newest expectation at the front, oldest at the back.
   result_type pending_results[$];
   int  error_count;
   int  cycle_count;
   bit  rx_stall_mode;

   ray_box_slab_intersect_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Near/far distance of one slab; returns 0 when a zero direction misses.
   function automatic bit slab_span(input longint lo, input longint hi,
                                    input longint org, input longint dir,
                                    output longint tn, output longint tf);
      tn = 0;
      tf = 0;
      if (dir == 0) begin
         if (org < lo || org > hi) return 1'b0;
         tn = -T_UNB;
         tf = T_UNB;
         return 1'b1;
      end
      if (dir > 0) begin
         tn = ((lo - org) * Q_ONE_L) / dir;
         tf = ((hi - org) * Q_ONE_L) / dir;
      end else begin
         tn = ((hi - org) * Q_ONE_L) / dir;
         tf = ((lo - org) * Q_ONE_L) / dir;
      end
      return 1'b1;
   endfunction

   function automatic logic [31:0] clamp_q(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic result_type slab_intersect(input ray_type r);
      longint org [3];
      longint dir [3];
      longint tn, tf, an, af;
      bit     hit;
      result_type res;
      org[0] = longint'(signed'(r.ox));
      org[1] = longint'(signed'(r.oy));
      org[2] = longint'(signed'(r.oz));
      dir[0] = longint'(signed'(r.dx));
      dir[1] = longint'(signed'(r.dy));
      dir[2] = longint'(signed'(r.dz));
      hit = slab_span(box_lo[0], box_hi[0], org[0], dir[0], tn, tf);
      // Each later slab is checked against the running interval, then narrows it.
      for (int a = 1; a < 3; a++) begin
         if (hit) begin
            if (!slab_span(box_lo[a], box_hi[a], org[a], dir[a], an, af)) begin
               hit = 1'b0;
            end else if (tn > af || an > tf) begin
               hit = 1'b0;
            end else begin
               if (an > tn) tn = an;
               if (af < tf) tf = af;
            end
         end
      end
      res.hit = hit;
      res.t_enter = hit ? clamp_q(tn) : 32'd0;
      res.t_exit = hit ? clamp_q(tf) : 32'd0;
      return res;
   endfunction

   // Acceptance on the request side feeds the predictor.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         pending_results.push_front(slab_intersect(ray_type'(req_tdata)));
      end
   end

   // Response checker.
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hit = rsp_tdata[0];
         got.t_enter = rsp_tdata[32:1];
         got.t_exit = rsp_tdata[64:33];
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected rsp transaction %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_back();
            if (got.hit !== want.hit) begin
               $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
               error_count++;
            end
            if (got.t_enter !== want.t_enter) begin
               $display("%0t: t_enter expected %h actual %h", $time,
                        want.t_enter, got.t_enter);
               error_count++;
            end
            if (got.t_exit !== want.t_exit) begin
               $display("%0t: t_exit expected %h actual %h", $time,
                        want.t_exit, got.t_exit);
               error_count++;
            end
         end
      end
   end

   // The receiver stalls on its own pattern: alternating calm and busy spells.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         rx_stall_mode <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) rx_stall_mode <= ~rx_stall_mode;
         rsp_tready <= rx_stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic write_box(input logic [2:0] idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx < REG_MAX_X) box_lo[idx] = longint'(signed'(val));
      else box_hi[idx - REG_MAX_X] = longint'(signed'(val));
   endtask

   task automatic set_box(input logic [31:0] lx, ly, lz, hx, hy, hz);
      write_box(REG_MIN_X, lx);
      write_box(REG_MIN_Y, ly);
      write_box(REG_MIN_Z, lz);
      write_box(REG_MAX_X, hx);
      write_box(REG_MAX_Y, hy);
      write_box(REG_MAX_Z, hz);
   endtask

   // Drive one ray and hold it until the request transaction is accepted.
   // Valid stays high across back-to-back rays inside a burst.
   task automatic send_ray(input ray_type r, input bit keep_valid);
      req_tvalid <= 1'b1;
      req_tdata <= r;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!keep_valid) req_tvalid <= 1'b0;
   endtask

   // Wait until every expected result is in, then let the pipeline settle.
   task automatic drain;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word;
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return $urandom_range(0, 1) ? 32'(-$urandom_range(1, 262144))
                                         : 32'($urandom_range(1, 262144));
         default: return $urandom;
      endcase
   endfunction

   // Origin coordinates mostly near the current box: a box bound or a point
   // around it, with some wild words mixed in.
   function automatic logic [31:0] near_box(input int a);
      longint span;
      span = box_hi[a] - box_lo[a];
      if (span < 0) span = -span;
      if ($urandom_range(0, 4) == 0) return rand_word();
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(0, 1) ? box_lo[a][31:0] : box_hi[a][31:0];
      return 32'(box_lo[a] + longint'($urandom_range(0, 32'(span + 1) * 3))
                 - span - 1);
   endfunction

   function automatic ray_type random_ray;
      ray_type r;
      r.ox = near_box(0);
      r.oy = near_box(1);
      r.oz = near_box(2);
      r.dx = ($urandom_range(0, 7) == 0) ? 32'h0 : rand_word();
      r.dy = ($urandom_range(0, 7) == 0) ? 32'h0 : rand_word();
      r.dz = ($urandom_range(0, 7) == 0) ? 32'h0 : rand_word();
      return r;
   endfunction

   task automatic random_phase(input int count);
      int left, burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         if (burst > left) burst = left;
         for (int i = 0; i < burst; i++) send_ray(random_ray(), i != burst - 1);
         left -= burst;
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   row_type directed_rows[$];

   task automatic add_row(input logic [31:0] ox, oy, oz, dx, dy, dz,
                          input bit fixed, input logic h,
                          input logic [31:0] te, input logic [31:0] tx);
      row_type row;
      row.ray = '{dz: dz, dy: dy, dx: dx, oz: oz, oy: oy, ox: ox};
      row.check_fixed = fixed;
      row.fixed_res = '{hit: h, t_enter: te, t_exit: tx};
      directed_rows = {directed_rows, row};
   endtask

   initial begin
      result_type model_res;
      error_count = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = REG_MIN_X;
      csr_wdata = '0;
      box_lo = '{0, 0, 0};
      box_hi = '{Q_ONE_L, Q_ONE_L, Q_ONE_L};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rays against the reset unit box.
      // Along +x from x = -1 at the centre: enters at 1, leaves at 2.
      add_row(32'hFFFF_0000, 32'h8000, 32'h8000, 32'h1_0000, 0, 0,
              1, 1, 32'h1_0000, 32'h2_0000);
      // Along -y from y = 2: enters at 1, leaves at 2.
      add_row(32'h8000, 32'h2_0000, 32'h8000, 0, 32'hFFFF_0000, 0,
              1, 1, 32'h1_0000, 32'h2_0000);
      // Zero direction with the origin outside the slab misses.
      add_row(32'h2_0000, 32'h8000, 32'h8000, 0, 32'h1_0000, 0, 1, 0, 0, 0);
      // Zero direction everywhere from inside: unbounded both ways.
      add_row(32'h8000, 32'h8000, 32'h8000, 0, 0, 0,
              1, 1, 32'h8000_0000, 32'h7FFF_FFFF);
      // Origin exactly on the box faces with zero direction still counts.
      add_row(0, 32'h1_0000, 0, 0, 0, 0, 1, 1, 32'h8000_0000, 32'h7FFF_FFFF);
      // Box behind the origin is still a hit, with negative distances.
      add_row(32'h3_0000, 32'h8000, 32'h8000, 32'h1_0000, 0, 0,
              1, 1, 32'hFFFD_0000, 32'hFFFE_0000);
      // Ray through a corner: the interval shrinks to a single point.
      add_row(32'hFFFF_0000, 32'h3_0000, 32'h8000, 32'h1_0000, 32'hFFFF_0000, 0,
              1, 1, 32'h2_0000, 32'h2_0000);
      // Diagonal ray that passes beside the box misses.
      add_row(32'hFFFF_0000, 32'h4_0000, 32'h8000, 32'h1_0000, 32'hFFFF_0000, 0,
              1, 0, 0, 0);
      // Tiny direction gives distances that saturate.
      add_row(32'h8000_0000, 32'h8000, 32'h8000, 32'h1, 0, 0, 0, 0, 0, 0);
      // Field extremes.
      add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 0, 0, 0, 0);
      add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0, 0);
      add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
      add_row(32'h8000, 32'h8000, 32'h8000, 32'h7FFF_FFFF, 32'h1, 32'h8000_0000,
              0, 0, 0, 0);
      // Zero direction on y and z, origin outside the z slab: miss after two slabs.
      add_row(32'hFFFF_0000, 32'h8000, 32'h5_0000, 32'h1_0000, 0, 0, 1, 0, 0, 0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].check_fixed) begin
            model_res = slab_intersect(directed_rows[i].ray);
            if (model_res !== directed_rows[i].fixed_res) begin
               $display("%0t: directed row %0d expected %h predictor %h", $time, i,
                        directed_rows[i].fixed_res, model_res);
               error_count++;
            end
         end
         send_ray(directed_rows[i].ray, i != directed_rows.size() - 1);
      end
      drain();

      // Extreme box: the full range on every axis.
      set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      random_phase(N_RANDOM / 6);
      drain();

      // Inverted box on every axis.
      set_box(32'h7FFF_FFFF, 32'h1_0000, 32'h0,
              32'h8000_0000, 32'hFFFF_0000, 32'hFFFF_FFFF);
      random_phase(N_RANDOM / 12);
      drain();

      // Five random boxes, all well formed; the last is flat on y.
      for (int p = 0; p < 5; p++) begin
         logic [31:0] lo3 [3];
         logic [31:0] hi3 [3];
         for (int a = 0; a < 3; a++) begin
            lo3[a] = 32'(-$urandom_range(0, 20 << 16));
            hi3[a] = 32'(longint'(signed'(lo3[a])) + $urandom_range(0, 30 << 16));
         end
         if (p == 4) hi3[1] = lo3[1];   // flat box on y
         set_box(lo3[0], lo3[1], lo3[2], hi3[0], hi3[1], hi3[2]);
         random_phase(N_RANDOM / 7);
         drain();
      end

      // Back to a small box near the origin for the rest.
      set_box(32'hFFFF_8000, 32'h0, 32'h1, 32'h8000, 32'h2_0000, 32'h3);
      random_phase(N_RANDOM / 8);
      drain();

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
